[rtl/core/lsd_pkg.sv]
`timescale 1ns / 1ps

package lsd_pkg;

    localparam int DATA_W              = 32;
    localparam int KIND_W              = 2;
    localparam int STATUS_W            = 2;
    localparam int COUNT_W             = 5;
    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int S_TDATA_W           = 32;
    localparam int M_TDATA_W           = 40;

    localparam logic [DATA_W-1:0] EMPTY_READ = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_DELETE = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_TOP  = 2'd0,
        RD_DOWN = 2'd1,
        RD_UP   = 2'd2
    } rd_sel_t;

    typedef enum logic {
        WR_PUSH  = 1'b0,
        WR_SHIFT = 1'b1
    } wr_sel_t;

    typedef enum logic [1:0] {
        VAL_ZERO  = 2'd0,
        VAL_ONES  = 2'd1,
        VAL_RDATA = 2'd2
    } val_sel_t;

    typedef struct packed {
        logic     load_op;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     res_load;
        val_sel_t res_val_sel;
        status_t  res_status;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  empty;
        logic  full;
        logic  match;
        logic  ptr_zero;
        logic  more_above;
        logic  out_free;
    } sts_t;

endpackage

[rtl/core/lsd_ctrl.sv]
`timescale 1ns / 1ps

module lsd_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lsd_pkg::sts_t sts,
    output lsd_pkg::cmd_t cmd
);
    import lsd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_RDWAIT = 6'b000100,
        S_SEARCH = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        cmd             = '0;
        cmd.rd_sel      = RD_TOP;
        cmd.wr_sel      = WR_PUSH;
        cmd.res_val_sel = VAL_ZERO;
        cmd.res_status  = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.kind)
                    KIND_PUSH:
                    begin
                        cmd.res_load = 1'b1;
                        if (sts.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = WR_PUSH;
                            cmd.cnt_inc = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    KIND_POP, KIND_PEEK:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_load    = 1'b1;
                            cmd.res_val_sel = VAL_ONES;
                            cmd.res_status  = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TOP;
                            state_next = S_RDWAIT;
                        end
                    end
                    default:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TOP;
                            state_next = S_SEARCH;
                        end
                    end
                endcase
            end
            S_RDWAIT:
            begin
                cmd.res_load    = 1'b1;
                cmd.res_val_sel = VAL_RDATA;
                cmd.cnt_dec     = (sts.kind == KIND_POP);
                state_next      = S_DONE;
            end
            S_SEARCH:
            begin
                if (sts.match)
                begin
                    if (sts.more_above)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_UP;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cmd.cnt_dec  = 1'b1;
                        cmd.res_load = 1'b1;
                        state_next   = S_DONE;
                    end
                end
                else if (sts.ptr_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DOWN;
                end
            end
            S_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                if (sts.more_above)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP;
                end
                else
                begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/lsd_dpath.sv]
`timescale 1ns / 1ps

module lsd_dpath
#(
    parameter int STACK_DEPTH = lsd_pkg::DEFAULT_STACK_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsd_pkg::cmd_t                 cmd,
    output lsd_pkg::sts_t                 sts,
    input  lsd_pkg::kind_t                in_kind,
    input  logic [lsd_pkg::DATA_W-1:0]    in_operand,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lsd_pkg::DATA_W-1:0]    out_read_value,
    output lsd_pkg::status_t              out_status,
    output logic [lsd_pkg::COUNT_W-1:0]   out_entry_count
);
    import lsd_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0]  mem [STACK_DEPTH];
    logic [DATA_W-1:0]  rd_data_reg;

    kind_t              kind_reg;
    logic [DATA_W-1:0]  operand_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [AW-1:0]      ptr_reg;
    logic [DATA_W-1:0]  res_value_reg;
    status_t            res_status_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  out_value_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [AW:0]        ptr_up_ext;
    logic [AW:0]        count_ext;
    logic [CW+COUNT_W-1:0] count_wide;

    assign ptr_up_ext = {1'b0, ptr_reg} + (AW + 1)'(1);
    assign count_ext  = (AW + 1)'(count_reg);
    assign count_wide = (CW + COUNT_W)'(count_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_TOP:  rd_addr = AW'(count_reg - CW'(1));
            RD_DOWN: rd_addr = ptr_reg - AW'(1);
            RD_UP:   rd_addr = ptr_up_ext[AW-1:0];
            default: rd_addr = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_PUSH:
            begin
                wr_addr = AW'(count_reg);
                wr_data = operand_reg;
            end
            default:
            begin
                wr_addr = ptr_reg - AW'(1);
                wr_data = rd_data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            kind_reg    <= in_kind;
            operand_reg <= in_operand;
        end
        if (cmd.rd_en)
        begin
            ptr_reg <= rd_addr;
        end
        if (cmd.res_load)
        begin
            case (cmd.res_val_sel)
                VAL_ONES:  res_value_reg <= EMPTY_READ;
                VAL_RDATA: res_value_reg <= rd_data_reg;
                default:   res_value_reg <= '0;
            endcase
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg == CW'(STACK_DEPTH));
    assign sts.match      = (rd_data_reg == operand_reg);
    assign sts.ptr_zero   = (ptr_reg == '0);
    assign sts.more_above = (ptr_up_ext < count_ext);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_read_value  = out_value_reg;
    assign out_status      = out_status_reg;
    assign out_entry_count = out_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("Entry count has gone beyond the stack depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en && (cmd.wr_sel == WR_PUSH) |-> !sts.full)
        else $error("A push was written into a full stack.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> !sts.empty)
        else $error("An entry was removed from an empty stack.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("A result overwrote one that had not been transferred.");

endmodule

[rtl/core/lifo_stack_with_delete.sv]
`timescale 1ns / 1ps
// Channel  Direction  tdata                                  tuser
// s_       in         [31:0] operand_value                   [1:0] kind
// m_       out        [31:0] read_value, [36:32] entry_count [1:0] status
//
// A push, or any operation that meets an empty stack, gets its result in the
// execute state; a pop or peek first waits in a read state for the top entry.
// A delete walks the stack one entry at a time: it searches from the top
// down, then moves each entry above the match down by one place.
// Reset clears the entry count and the output valid flag; entries need no
// clearing. One result may wait in the output register while the next item
// is taken; a further result waits until m_tready takes the previous one.

module lifo_stack_with_delete
#(
    parameter int STACK_DEPTH = lsd_pkg::DEFAULT_STACK_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lsd_pkg::S_TDATA_W-1:0]    s_tdata,  // operand_value
    input  logic [lsd_pkg::KIND_W-1:0]       s_tuser,  // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsd_pkg::M_TDATA_W-1:0]    m_tdata,  // read_value, entry_count
    output logic [lsd_pkg::STATUS_W-1:0]     m_tuser   // status
);
    import lsd_pkg::*;

    cmd_t                cmd;
    sts_t                sts;
    logic [DATA_W-1:0]   read_value;
    status_t             status;
    logic [COUNT_W-1:0]  entry_count;

    lsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsd_dpath
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_kind         (kind_t'(s_tuser)),
        .in_operand      (s_tdata[DATA_W-1:0]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_read_value  (read_value),
        .out_status      (status),
        .out_entry_count (entry_count)
    );

    assign m_tdata = {(M_TDATA_W - DATA_W - COUNT_W)'(0), entry_count, read_value};
    assign m_tuser = status;

endmodule

[tb/tb_lifo_stack_with_delete.sv]
`timescale 1ns / 1ps

module tb_lifo_stack_with_delete;

    import lsd_pkg::*;

    localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 445;

    typedef struct {
        kind_t       kind;
        logic [31:0] operand;
        int          phase;
        bit          drain_first;
        bit          hold_rx;
    } stack_op_t;

    typedef struct {
        logic [31:0]        value;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } stack_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = KIND_PUSH;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    stack_op_t     op_queue[$];
    stack_result_t expected_results[$];
    stack_op_t     cur_op;

    logic [31:0] stack_model[STACK_DEPTH];
    int          stack_fill = 0;
    logic [31:0] value_pool[8];

    int n_accepted = 0;
    int n_done = 0;
    int n_errors = 0;
    int rx_idle_pct = 63;
    int hold_left = 0;
    bit hold_start = 1'b0;

    lifo_stack_with_delete u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic int tx_idle_for(input int phase);
        return (phase == 0) ? 20 : (phase == 1) ? 63 : 0;
    endfunction

    function automatic int rx_idle_for(input int phase);
        return (phase == 0) ? 63 : (phase == 1) ? 20 : 0;
    endfunction

    function automatic stack_result_t apply_stack_op(input kind_t op, input logic [31:0] operand);
        stack_result_t r;
        int            pos;
        bit            found;
        r.value = '0;
        r.status = ST_OK;
        case (op)
            KIND_PUSH:
            begin
                if (stack_fill >= STACK_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    stack_model[stack_fill] = operand;
                    stack_fill++;
                end
            end
            KIND_POP, KIND_PEEK:
            begin
                if (stack_fill == 0)
                begin
                    r.value = EMPTY_READ;
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.value = stack_model[stack_fill-1];
                    if (op == KIND_POP)
                        stack_fill--;
                end
            end
            default:
            begin
                if (stack_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    found = 1'b0;
                    pos = stack_fill - 1;
                    while (pos >= 0 && !found)
                    begin
                        if (stack_model[pos] == operand)
                            found = 1'b1;
                        else
                            pos--;
                    end
                    if (found)
                    begin
                        for (int k = pos; k + 1 < stack_fill; k++)
                            stack_model[k] = stack_model[k+1];
                        stack_fill--;
                    end
                    else
                        r.status = ST_NOT_FOUND;
                end
            end
        endcase
        r.count = COUNT_W'(stack_fill);
        return r;
    endfunction

    task automatic add_op(input kind_t kind, input logic [31:0] operand, input int phase,
                          input bit drain_first, input bit hold_rx);
        stack_op_t op;
        op.kind = kind;
        op.operand = operand;
        op.phase = phase;
        op.drain_first = drain_first;
        op.hold_rx = hold_rx;
        op_queue.push_back(op);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 75)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    function automatic kind_t pick_kind(input int mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            0:       return (r < 75) ? KIND_PUSH : (r < 85) ? KIND_DELETE :
                            (r < 93) ? KIND_PEEK : KIND_POP;
            1:       return (r < 20) ? KIND_PUSH : (r < 60) ? KIND_POP :
                            (r < 80) ? KIND_DELETE : KIND_PEEK;
            default: return kind_t'($urandom_range(3));
        endcase
    endfunction

    // Sender: holds each transfer until accepted and predicts its result on acceptance.
    always @(posedge clk or negedge rst_n)
    begin : sender
        stack_op_t     nxt;
        stack_result_t res;
        bit            accepting;
        bit            start_hold;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= KIND_PUSH;
            hold_start <= 1'b0;
        end
        else
        begin
            accepting = s_tvalid && s_tready;
            start_hold = 1'b0;
            if (accepting)
            begin
                res = apply_stack_op(cur_op.kind, cur_op.operand);
                expected_results.push_back(res);
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (op_queue.size() > 0
                    && $urandom_range(99) >= tx_idle_for(op_queue[0].phase)
                    && (!op_queue[0].drain_first || (!accepting && n_accepted == n_done)))
                begin
                    nxt = op_queue.pop_front();
                    cur_op = nxt;
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.operand;
                    s_tuser <= nxt.kind;
                    rx_idle_pct <= rx_idle_for(nxt.phase);
                    start_hold = nxt.hold_rx;
                end
                else
                    s_tvalid <= 1'b0;
            end
            hold_start <= start_hold;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_start)
        begin
            m_tready <= 1'b0;
            hold_left <= RX_HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        stack_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_done <= n_done + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result read_value=%h status=%0d entry_count=%0d",
                         $time, m_tdata[31:0], m_tuser, m_tdata[36:32]);
                n_errors++;
            end
            else
            begin
                exp = expected_results.pop_front();
                if (m_tdata[31:0] !== exp.value)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, exp.value, m_tdata[31:0]);
                    n_errors++;
                end
                if (m_tuser !== exp.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp.status, m_tuser);
                    n_errors++;
                end
                if (m_tdata[36:32] !== exp.count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp.count, m_tdata[36:32]);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int mode;
        int burst_left;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h7FFF_FFFF;
        value_pool[3] = 32'h8000_0000;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        add_op(KIND_POP, 32'h1234_5678, 0, 1'b0, 1'b0);
        add_op(KIND_PEEK, 32'h0, 0, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h0, 0, 1'b0, 1'b0);
        add_op(KIND_PUSH, 32'h7FFF_FFFF, 0, 1'b0, 1'b0);
        add_op(KIND_PUSH, 32'h8000_0000, 0, 1'b0, 1'b0);
        add_op(KIND_PUSH, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
        add_op(KIND_PUSH, 32'h0000_0000, 0, 1'b0, 1'b0);
        add_op(KIND_PUSH, 32'h7FFF_FFFF, 0, 1'b0, 1'b0);
        add_op(KIND_PEEK, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h7FFF_FFFF, 0, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h0000_3039, 0, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h8000_0000, 0, 1'b0, 1'b0);
        add_op(KIND_PEEK, 32'h0, 0, 1'b0, 1'b0);
        add_op(KIND_POP, 32'h0, 0, 1'b0, 1'b0);
        add_op(KIND_POP, 32'h0, 0, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h7FFF_FFFF, 0, 1'b0, 1'b0);
        add_op(KIND_POP, 32'h0, 0, 1'b0, 1'b0);
        add_op(KIND_PEEK, 32'h0, 0, 1'b0, 1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            burst_left = 0;
            mode = 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (burst_left == 0)
                begin
                    mode = $urandom_range(2);
                    burst_left = $urandom_range(8, 30);
                end
                burst_left--;
                add_op(pick_kind(mode), pick_value(), phase, i == 0, i == 100);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() > 0 || s_tvalid)
            @(posedge clk);
        while (n_accepted != n_done)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
